[design/hfse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfse_pkg
// Shared types, constants and table functions of the Haar feature evaluator.
// ----------------------------------------------------------------------------
package hfse_pkg;

    localparam int COORD_W     = 5;
    localparam int LSUM_W      = 18;
    localparam int VAL_W       = 21;
    localparam int DIM_W       = 9;
    localparam int NUM_TERMS   = 9;
    localparam int TERM_IDX_W  = 4;
    localparam int PROD_W      = 9;
    localparam int MAG_W       = 8;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int WT_W        = 4;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int VAL_MAX     = 1048575;
    localparam int VAL_MIN     = -1048576;

    localparam logic [1:0] REG_KIND      = 2'd0;
    localparam logic [1:0] REG_ROW_SPLIT = 2'd1;
    localparam logic [1:0] REG_COL_SPLIT = 2'd2;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_ROW2     = 3'd1;
    localparam logic [2:0] KIND_COL2     = 3'd2;
    localparam logic [2:0] KIND_ROW3     = 3'd3;
    localparam logic [2:0] KIND_COL3     = 3'd4;
    localparam logic [2:0] KIND_CHECK    = 3'd5;
    localparam logic [2:0] KIND_COL3_INV = 3'd6;
    localparam logic [2:0] KIND_ROW2_INV = 3'd7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [1:0] {RS_T, RS_B, RS_R1, RS_R3} rsel_t;
    typedef enum logic [1:0] {CS_L, CS_R, CS_C1, CS_C2} csel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_QUOT,
        ST_READ,
        ST_DRAIN,
        ST_FINAL
    } state_t;

    typedef struct packed {
        rsel_t                  rsel;
        csel_t                  csel;
        logic signed [WT_W-1:0] wt;
    } term_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] row_split;
        logic [3:0] col_split;
    } cfg_t;

    typedef struct packed {
        logic                  capture;
        logic                  load_wr;
        logic                  prod_en;
        logic                  quot_en;
        logic                  rd_en;
        logic [TERM_IDX_W-1:0] rd_idx;
        logic                  acc_clr;
        logic                  out_load;
    } dp_cmd_t;

    function automatic logic [3:0] clamp_div(input logic [3:0] v);
        logic [3:0] d;
        if (v < 4'd2) begin
            d = 4'd2;
        end else if (v > 4'd8) begin
            d = 4'd8;
        end else begin
            d = v;
        end
        return d;
    endfunction

    // Reciprocal scaled by 2**16 and rounded up; exact for products below 256.
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
        logic [RECIP_W-1:0] m;
        unique case (d)
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            default: m = 17'd32768;
        endcase
        return m;
    endfunction

    function automatic logic [COORD_W-1:0] split_point(
        input logic [COORD_W-1:0]       a,
        input logic signed [PROD_W-1:0] p,
        input logic [RECIP_W-1:0]       m
    );
        logic [MAG_W-1:0]           mag;
        logic [MAG_W+RECIP_W-1:0]   full;
        logic [MAG_W-1:0]           q;
        logic signed [PROD_W+1:0]   qs;
        logic signed [PROD_W+1:0]   sum;
        mag  = p[PROD_W-1] ? MAG_W'(-p) : MAG_W'(p);
        full = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(m);
        q    = full[RECIP_SHIFT +: MAG_W];
        qs   = (PROD_W+2)'(signed'({1'b0, q}));
        sum  = (PROD_W+2)'(signed'({1'b0, a})) + (p[PROD_W-1] ? -qs : qs);
        return sum[COORD_W-1:0];
    endfunction

    function automatic term_t mk_term(input rsel_t r, input csel_t c, input int w);
        term_t t;
        t.rsel = r;
        t.csel = c;
        t.wt   = WT_W'(w);
        return t;
    endfunction

    // Each feature kind is a weighted sum of at most nine integral words.
    function automatic term_t term_lookup(
        input logic [2:0]            kind,
        input logic [TERM_IDX_W-1:0] idx
    );
        term_t      t;
        logic       neg;
        logic [2:0] base;
        t    = mk_term(RS_T, CS_L, 0);
        neg  = (kind == KIND_ROW2_INV) || (kind == KIND_COL3_INV);
        base = (kind == KIND_ROW2_INV) ? KIND_ROW2 :
               (kind == KIND_COL3_INV) ? KIND_COL3 : kind;
        unique case (base)
            KIND_ROW2: begin
                case (idx)
                    4'd0: t = mk_term(RS_R1, CS_R, 2);
                    4'd1: t = mk_term(RS_R1, CS_L, -2);
                    4'd2: t = mk_term(RS_T,  CS_L, 1);
                    4'd3: t = mk_term(RS_T,  CS_R, -1);
                    4'd4: t = mk_term(RS_B,  CS_R, -1);
                    4'd5: t = mk_term(RS_B,  CS_L, 1);
                    default: ;
                endcase
            end
            KIND_COL2: begin
                case (idx)
                    4'd0: t = mk_term(RS_B, CS_C1, 2);
                    4'd1: t = mk_term(RS_T, CS_C1, -2);
                    4'd2: t = mk_term(RS_T, CS_L,  1);
                    4'd3: t = mk_term(RS_B, CS_L,  -1);
                    4'd4: t = mk_term(RS_B, CS_R,  -1);
                    4'd5: t = mk_term(RS_T, CS_R,  1);
                    default: ;
                endcase
            end
            KIND_ROW3: begin
                case (idx)
                    4'd0: t = mk_term(RS_R1, CS_R, 3);
                    4'd1: t = mk_term(RS_R1, CS_L, -3);
                    4'd2: t = mk_term(RS_R3, CS_L, 3);
                    4'd3: t = mk_term(RS_R3, CS_R, -3);
                    4'd4: t = mk_term(RS_T,  CS_L, 1);
                    4'd5: t = mk_term(RS_T,  CS_R, -1);
                    4'd6: t = mk_term(RS_B,  CS_R, 1);
                    4'd7: t = mk_term(RS_B,  CS_L, -1);
                    default: ;
                endcase
            end
            KIND_COL3: begin
                case (idx)
                    4'd0: t = mk_term(RS_B, CS_C1, 3);
                    4'd1: t = mk_term(RS_T, CS_C1, -3);
                    4'd2: t = mk_term(RS_T, CS_C2, 3);
                    4'd3: t = mk_term(RS_B, CS_C2, -3);
                    4'd4: t = mk_term(RS_T, CS_L,  1);
                    4'd5: t = mk_term(RS_B, CS_L,  -1);
                    4'd6: t = mk_term(RS_B, CS_R,  1);
                    4'd7: t = mk_term(RS_T, CS_R,  -1);
                    default: ;
                endcase
            end
            KIND_CHECK: begin
                case (idx)
                    4'd0: t = mk_term(RS_R1, CS_C1, 4);
                    4'd1: t = mk_term(RS_R1, CS_R,  -2);
                    4'd2: t = mk_term(RS_B,  CS_C1, -2);
                    4'd3: t = mk_term(RS_T,  CS_C1, -2);
                    4'd4: t = mk_term(RS_R1, CS_L,  -2);
                    4'd5: t = mk_term(RS_B,  CS_R,  1);
                    4'd6: t = mk_term(RS_T,  CS_L,  1);
                    4'd7: t = mk_term(RS_B,  CS_L,  1);
                    4'd8: t = mk_term(RS_T,  CS_R,  1);
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (neg) begin
            t.wt = -t.wt;
        end
        return t;
    endfunction

endpackage

[design/hfse_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfse_ctrl
// Sequencer that accepts load requests and steps an evaluate request through split, read and result.
// ----------------------------------------------------------------------------
module hfse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_op,
    output logic              s_ready,
    input  logic              m_ready,
    output logic              m_valid,
    output hfse_pkg::dp_cmd_t cmd
);

    hfse_pkg::state_t                      state_reg, state_next;
    logic [hfse_pkg::TERM_IDX_W-1:0]       idx_reg, idx_next;
    logic                                  m_valid_reg, m_valid_next;
    logic                                  accept;
    logic                                  out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hfse_pkg::ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            hfse_pkg::ST_IDLE: begin
                if (accept && s_op == hfse_pkg::OP_EVAL) begin
                    state_next = hfse_pkg::ST_PROD;
                end
            end
            hfse_pkg::ST_PROD: state_next = hfse_pkg::ST_QUOT;
            hfse_pkg::ST_QUOT: begin
                state_next = hfse_pkg::ST_READ;
                idx_next   = '0;
            end
            hfse_pkg::ST_READ: begin
                if (idx_reg == hfse_pkg::TERM_IDX_W'(hfse_pkg::NUM_TERMS - 1)) begin
                    state_next = hfse_pkg::ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            hfse_pkg::ST_DRAIN: state_next = hfse_pkg::ST_FINAL;
            hfse_pkg::ST_FINAL: begin
                if (out_free) begin
                    state_next = hfse_pkg::ST_IDLE;
                end
            end
            default: state_next = hfse_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == hfse_pkg::ST_IDLE);
        cmd          = '0;
        cmd.rd_idx   = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            hfse_pkg::ST_IDLE: begin
                cmd.capture = accept && s_op == hfse_pkg::OP_EVAL;
                cmd.load_wr = accept && s_op == hfse_pkg::OP_LOAD;
            end
            hfse_pkg::ST_PROD: cmd.prod_en = 1'b1;
            hfse_pkg::ST_QUOT: begin
                cmd.quot_en = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            hfse_pkg::ST_READ: cmd.rd_en = 1'b1;
            hfse_pkg::ST_FINAL: begin
                cmd.out_load = out_free;
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while still pending");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (idx_reg < hfse_pkg::TERM_IDX_W'(hfse_pkg::NUM_TERMS)))
        else $error("read index beyond term list");

    a_eval_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == hfse_pkg::OP_EVAL) |=> (state_reg == hfse_pkg::ST_PROD))
        else $error("evaluate request did not start");

    a_read_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hfse_pkg::ST_READ &&
         idx_reg == hfse_pkg::TERM_IDX_W'(hfse_pkg::NUM_TERMS - 1))
        |=> (state_reg == hfse_pkg::ST_DRAIN))
        else $error("read sequence did not end after last term");

endmodule

[design/hfse_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfse_dp
// Integral image store, split point arithmetic, weighted accumulator and
// stump decision.
// ----------------------------------------------------------------------------
module hfse_dp #(
    parameter int IMG_ROWS = 32,
    parameter int IMG_COLS = 32,
    parameter int SUM_BITS = 18
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hfse_pkg::dp_cmd_t                     cmd,
    input  hfse_pkg::cfg_t                        cfg,
    input  logic [hfse_pkg::COORD_W-1:0]          s_load_row,
    input  logic [hfse_pkg::COORD_W-1:0]          s_load_col,
    input  logic [hfse_pkg::LSUM_W-1:0]           s_load_sum,
    input  logic [hfse_pkg::COORD_W-1:0]          s_top_row,
    input  logic [hfse_pkg::COORD_W-1:0]          s_left_col,
    input  logic [hfse_pkg::COORD_W-1:0]          s_bottom_row,
    input  logic [hfse_pkg::COORD_W-1:0]          s_right_col,
    input  logic signed [hfse_pkg::VAL_W-1:0]     s_stump_threshold,
    input  logic                                  s_polarity,
    output logic signed [hfse_pkg::VAL_W-1:0]     m_feature_value,
    output logic                                  m_is_positive
);

    localparam int DEPTH  = IMG_ROWS * IMG_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = SUM_BITS + 6;
    localparam int CMP_W  = ((ACC_W > hfse_pkg::VAL_W) ? ACC_W : hfse_pkg::VAL_W) + 1;
    localparam logic [hfse_pkg::DIM_W-1:0] ROW_LIM = hfse_pkg::DIM_W'(IMG_ROWS);
    localparam logic [hfse_pkg::DIM_W-1:0] COL_LIM = hfse_pkg::DIM_W'(IMG_COLS);
    localparam logic signed [CMP_W-1:0] SAT_MAX = CMP_W'(hfse_pkg::VAL_MAX);
    localparam logic signed [CMP_W-1:0] SAT_MIN = CMP_W'(hfse_pkg::VAL_MIN);

    localparam int CW = hfse_pkg::COORD_W;
    localparam int PW = hfse_pkg::PROD_W;

    logic [SUM_BITS-1:0] integral_mem [DEPTH];

    logic [CW-1:0] top_reg, left_reg, bot_reg, right_reg;
    logic signed [hfse_pkg::VAL_W-1:0] thr_reg;
    logic                              pol_reg;
    logic signed [PW-1:0] p_r1_reg, p_r3_reg, p_c1_reg, p_c2_reg;
    logic [CW-1:0] r1_reg, r3_reg, c1_reg, c2_reg;
    logic [SUM_BITS-1:0] rdata_reg;
    logic signed [hfse_pkg::WT_W-1:0] wt_reg;
    logic rd_vld_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [hfse_pkg::VAL_W-1:0] fv_reg;
    logic pos_reg;

    logic [3:0]            row_div, col_div;
    logic signed [CW:0]    row_diff, col_diff;
    hfse_pkg::term_t       term;
    logic [CW-1:0]         rd_row, rd_col;
    logic                  rd_in_range, ld_in_range;
    logic [ADDR_W-1:0]     rd_addr, ld_addr;
    logic signed [CMP_W-1:0] acc_x, thr_x, sat_x;
    logic                  pos_now;

    assign row_div  = hfse_pkg::clamp_div(cfg.row_split);
    assign col_div  = hfse_pkg::clamp_div(cfg.col_split);
    assign row_diff = signed'({1'b0, bot_reg}) - signed'({1'b0, top_reg});
    assign col_diff = signed'({1'b0, right_reg}) - signed'({1'b0, left_reg});

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            top_reg   <= s_top_row;
            left_reg  <= s_left_col;
            bot_reg   <= s_bottom_row;
            right_reg <= s_right_col;
            thr_reg   <= s_stump_threshold;
            pol_reg   <= s_polarity;
        end
        if (cmd.prod_en) begin
            p_r1_reg <= PW'(row_diff);
            p_r3_reg <= PW'(row_diff) * PW'(signed'({1'b0, row_div - 4'd1}));
            p_c1_reg <= PW'(col_diff);
            p_c2_reg <= PW'(col_diff) * PW'(signed'({1'b0, col_div - 4'd1}));
        end
        if (cmd.quot_en) begin
            r1_reg <= hfse_pkg::split_point(top_reg, p_r1_reg, hfse_pkg::recip(row_div));
            r3_reg <= hfse_pkg::split_point(top_reg, p_r3_reg, hfse_pkg::recip(row_div));
            c1_reg <= hfse_pkg::split_point(left_reg, p_c1_reg, hfse_pkg::recip(col_div));
            c2_reg <= hfse_pkg::split_point(left_reg, p_c2_reg, hfse_pkg::recip(col_div));
        end
    end

    always_comb begin
        term = hfse_pkg::term_lookup(cfg.kind, cmd.rd_idx);
        unique case (term.rsel)
            hfse_pkg::RS_T:  rd_row = top_reg;
            hfse_pkg::RS_B:  rd_row = bot_reg;
            hfse_pkg::RS_R1: rd_row = r1_reg;
            hfse_pkg::RS_R3: rd_row = r3_reg;
            default:         rd_row = top_reg;
        endcase
        unique case (term.csel)
            hfse_pkg::CS_L:  rd_col = left_reg;
            hfse_pkg::CS_R:  rd_col = right_reg;
            hfse_pkg::CS_C1: rd_col = c1_reg;
            hfse_pkg::CS_C2: rd_col = c2_reg;
            default:         rd_col = left_reg;
        endcase
    end

    assign rd_in_range = (hfse_pkg::DIM_W'(rd_row) < ROW_LIM) &&
                         (hfse_pkg::DIM_W'(rd_col) < COL_LIM);
    assign ld_in_range = (hfse_pkg::DIM_W'(s_load_row) < ROW_LIM) &&
                         (hfse_pkg::DIM_W'(s_load_col) < COL_LIM);
    assign rd_addr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(IMG_COLS) + ADDR_W'(rd_col));
    assign ld_addr = ADDR_W'(ADDR_W'(s_load_row) * ADDR_W'(IMG_COLS) + ADDR_W'(s_load_col));

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && ld_in_range) begin
            integral_mem[ld_addr] <= SUM_BITS'(s_load_sum);
        end else if (cmd.rd_en) begin
            rdata_reg <= integral_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            wt_reg <= rd_in_range ? term.wt : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_clr) begin
            acc_next = '0;
        end else if (rd_vld_reg) begin
            acc_next = acc_reg + ACC_W'(signed'({1'b0, rdata_reg})) * ACC_W'(wt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_comb begin
        acc_x   = CMP_W'(acc_reg);
        thr_x   = CMP_W'(thr_reg);
        pos_now = pol_reg ? (acc_x > thr_x) : (acc_x < thr_x);
        if (acc_x > SAT_MAX) begin
            sat_x = SAT_MAX;
        end else if (acc_x < SAT_MIN) begin
            sat_x = SAT_MIN;
        end else begin
            sat_x = acc_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            fv_reg  <= sat_x[hfse_pkg::VAL_W-1:0];
            pos_reg <= pos_now;
        end
    end

    assign m_feature_value = fv_reg;
    assign m_is_positive   = pos_reg;

endmodule

[design/haar_feature_stump_eval_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haar_feature_stump_eval_core
// Haar-like feature evaluator over a stored integral image with a decision
// stump result and an APB register port.
// ----------------------------------------------------------------------------
// A load request writes the store on acceptance and leaves the sequencer idle.
// An evaluate request steps through PROD, QUOT, READ, DRAIN and FINAL; FINAL
// registers the result and returns to IDLE once the output is free.
// READ issues nine reads, one per cycle, from the single-port store.
// A pending result does not stop acceptance; it stalls only the next result.
// Reset clears control state and sets the registers to kind 1, splits 2 and 2;
// the image store is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
module haar_feature_stump_eval_core #(
    parameter int IMG_ROWS = 32,
    parameter int IMG_COLS = 32,
    parameter int SUM_BITS = 18
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_op,
    input  logic [hfse_pkg::COORD_W-1:0]          s_load_row,
    input  logic [hfse_pkg::COORD_W-1:0]          s_load_col,
    input  logic [hfse_pkg::LSUM_W-1:0]           s_load_sum,
    input  logic [hfse_pkg::COORD_W-1:0]          s_top_row,
    input  logic [hfse_pkg::COORD_W-1:0]          s_left_col,
    input  logic [hfse_pkg::COORD_W-1:0]          s_bottom_row,
    input  logic [hfse_pkg::COORD_W-1:0]          s_right_col,
    input  logic signed [hfse_pkg::VAL_W-1:0]     s_stump_threshold,
    input  logic                                  s_polarity,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [hfse_pkg::VAL_W-1:0]     m_feature_value,
    output logic                                  m_is_positive,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hfse_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [hfse_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [hfse_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    logic [2:0] kind_reg;
    logic [3:0] row_split_reg;
    logic [3:0] col_split_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    hfse_pkg::cfg_t    cfg;
    hfse_pkg::dp_cmd_t cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= hfse_pkg::KIND_ROW2;
            row_split_reg <= 4'd2;
            col_split_reg <= 4'd2;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                hfse_pkg::REG_KIND:      kind_reg      <= pwdata[2:0];
                hfse_pkg::REG_ROW_SPLIT: row_split_reg <= pwdata[3:0];
                hfse_pkg::REG_COL_SPLIT: col_split_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hfse_pkg::REG_KIND:      prdata = hfse_pkg::CFG_DATA_W'(kind_reg);
            hfse_pkg::REG_ROW_SPLIT: prdata = hfse_pkg::CFG_DATA_W'(row_split_reg);
            hfse_pkg::REG_COL_SPLIT: prdata = hfse_pkg::CFG_DATA_W'(col_split_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.kind      = kind_reg;
    assign cfg.row_split = row_split_reg;
    assign cfg.col_split = col_split_reg;

    hfse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    hfse_dp #(
        .IMG_ROWS (IMG_ROWS),
        .IMG_COLS (IMG_COLS),
        .SUM_BITS (SUM_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg               (cfg),
        .s_load_row        (s_load_row),
        .s_load_col        (s_load_col),
        .s_load_sum        (s_load_sum),
        .s_top_row         (s_top_row),
        .s_left_col        (s_left_col),
        .s_bottom_row      (s_bottom_row),
        .s_right_col       (s_right_col),
        .s_stump_threshold (s_stump_threshold),
        .s_polarity        (s_polarity),
        .m_feature_value   (m_feature_value),
        .m_is_positive     (m_is_positive)
    );

endmodule
